@@ rtl/sorted_timer_job_queue_defines.svh @@
// ----------------------------------------------------------------------------
// sorted timer job queue assertion macros
// shared property forms for the checker of the job queue
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_JOB_QUEUE_DEFINES_SVH
`define SORTED_TIMER_JOB_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define STQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define STQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// types and constants shared by the sorted timer job queue
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int ID_W        = 4;
	localparam int TICK_W      = 32;
	localparam int STATUS_W    = 3;
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 8;
	localparam int FIFO_DEPTH  = 2;

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_RUN     = 2'd1,
		CMD_RESCHED = 2'd2,
		CMD_DELETE  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 3'd0,
		ST_FIRED  = 3'd1,
		ST_NONE   = 3'd2,
		ST_QUEUED = 3'd3,
		ST_NOTQ   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_INSERT,
		BK_DELETE,
		BK_RUN
	} back_state_t;

	// decoded command handed from the front to the back
	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   job_id;
		logic              bad_id;
		logic [TICK_W-1:0] tick;
		logic [TICK_W-1:0] period;
	} cmd_item_t;

endpackage

@@ rtl/stq_front.sv @@
// ----------------------------------------------------------------------------
// stq_front
// input stage: takes commands, decodes them and flags job ids beyond the slots
// ----------------------------------------------------------------------------
module stq_front import stq_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // job_id, tick_value, repeat_period, pad
	input  logic [IN_TUSER_W-1:0] s_axis_tuser,  // cmd
	output logic                  item_vld,
	input  logic                  item_rdy,
	output cmd_item_t             item
);

	logic      vld_s1;
	cmd_item_t item_s1;
	cmd_item_t dec;

	always_comb begin
		dec.cmd    = cmd_t'(s_axis_tuser);
		dec.job_id = s_axis_tdata[ID_W-1:0];
		dec.tick   = s_axis_tdata[ID_W +: TICK_W];
		dec.period = s_axis_tdata[ID_W+TICK_W +: TICK_W];
		// run names no job, so it is never out of range
		dec.bad_id = (dec.cmd != CMD_RUN) && ({1'b0, dec.job_id} >= (ID_W+1)'(SLOTS));
	end

	assign s_axis_tready = !vld_s1 || item_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= dec;
		end
	end

	assign item_vld = vld_s1;
	assign item     = item_s1;

endmodule

@@ rtl/stq_fifo.sv @@
// ----------------------------------------------------------------------------
// stq_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module stq_fifo import stq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_vld,
	output logic      push_rdy,
	input  cmd_item_t push_item,
	output logic      pop_vld,
	input  logic      pop_rdy,
	output cmd_item_t pop_item
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	cmd_item_t       mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_rdy = (count_q != CW'(FIFO_DEPTH));
	assign pop_vld  = (count_q != '0);
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/stq_back.sv @@
// ----------------------------------------------------------------------------
// stq_back
// runs queued commands on the ordered list, one entry a cycle unless stalled
// ----------------------------------------------------------------------------
module stq_back import stq_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_vld,
	output logic                   item_pop,
	input  cmd_item_t              item,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // fired_job, pad
	output logic [STATUS_W-1:0]    m_axis_tuser,  // status
	output logic                   m_axis_tlast   // last
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	// job store and ordered list
	logic [ID_W-1:0]   order_q [SLOTS];
	logic [CW-1:0]     count_q;
	logic [TICK_W-1:0] due_q [SLOTS];
	logic [TICK_W-1:0] per_q [SLOTS];
	logic [SLOTS-1:0]  inq_q;

	// command context
	back_state_t       state_q, state_d;
	logic [CW-1:0]     pos_q;
	logic [TICK_W-1:0] key_q;
	logic [ID_W-1:0]   id_q;
	logic              pend_vld_q;
	logic [ID_W-1:0]   pend_id_q;

	// output register
	logic              out_vld_q;
	status_t           out_st_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q;

	// datapath
	logic              out_free;
	logic [IW-1:0]     hid;
	logic [ID_W-1:0]   head_id;
	logic [IW-1:0]     rd_idx;
	logic [TICK_W-1:0] rd_due;
	logic [TICK_W-1:0] rd_per;
	logic [TICK_W:0]   sum;
	logic [TICK_W-1:0] sat;
	logic              scan_hit;

	// controls
	logic              emit;
	status_t           emit_st;
	logic [ID_W-1:0]   emit_id;
	logic              emit_last;
	logic              due_we;
	logic [TICK_W-1:0] due_wd;
	logic              per_we;
	logic              inq_set;
	logic              inq_clr;
	logic [IW-1:0]     inq_clr_idx;
	logic              ins_do;
	logic              rm_do;
	logic              pos_inc;
	logic              pos_clr;
	logic              ctx_ld;
	logic [TICK_W-1:0] key_d;
	logic              pend_ld;
	logic              pend_vld_d;

	assign out_free = !out_vld_q || m_axis_tready;
	assign hid      = item.job_id[IW-1:0];
	assign head_id  = order_q[pos_q[IW-1:0]];
	assign rd_idx   = (state_q == BK_IDLE) ? hid : head_id[IW-1:0];
	assign rd_due   = due_q[rd_idx];
	assign rd_per   = per_q[rd_idx];
	assign sum      = {1'b0, rd_due} + {1'b0, rd_per};
	assign sat      = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
	// list entry at pos is due no later than the key
	assign scan_hit = (pos_q < count_q) && (rd_due <= key_q);

	always_comb begin
		state_d     = state_q;
		item_pop    = 1'b0;
		emit        = 1'b0;
		emit_st     = ST_DONE;
		emit_id     = '0;
		emit_last   = 1'b1;
		due_we      = 1'b0;
		due_wd      = item.tick;
		per_we      = 1'b0;
		inq_set     = 1'b0;
		inq_clr     = 1'b0;
		inq_clr_idx = id_q[IW-1:0];
		ins_do      = 1'b0;
		rm_do       = 1'b0;
		pos_inc     = 1'b0;
		pos_clr     = 1'b0;
		ctx_ld      = 1'b0;
		key_d       = item.tick;
		pend_ld     = 1'b0;
		pend_vld_d  = pend_vld_q;
		unique case (state_q)
			BK_IDLE: begin
				if (item_vld && out_free) begin
					item_pop = 1'b1;
					emit_id  = item.job_id;
					if (item.bad_id) begin
						emit    = 1'b1;
						emit_st = ST_NOTQ;
					end else begin
						unique case (item.cmd)
							CMD_RUN: begin
								ctx_ld     = 1'b1;
								pos_clr    = 1'b1;
								pend_vld_d = 1'b0;
								state_d    = BK_RUN;
							end
							CMD_CREATE: begin
								if (inq_q[hid]) begin
									emit    = 1'b1;
									emit_st = ST_QUEUED;
								end else begin
									due_we  = 1'b1;
									per_we  = 1'b1;
									ctx_ld  = 1'b1;
									pos_clr = 1'b1;
									state_d = BK_INSERT;
								end
							end
							CMD_RESCHED: begin
								if (inq_q[hid]) begin
									emit    = 1'b1;
									emit_st = ST_QUEUED;
								end else begin
									due_we  = 1'b1;
									due_wd  = sat;
									key_d   = sat;
									ctx_ld  = 1'b1;
									pos_clr = 1'b1;
									state_d = BK_INSERT;
								end
							end
							CMD_DELETE: begin
								if (!inq_q[hid]) begin
									emit    = 1'b1;
									emit_st = ST_NOTQ;
								end else begin
									ctx_ld  = 1'b1;
									pos_clr = 1'b1;
									state_d = BK_DELETE;
								end
							end
							default: begin
								emit    = 1'b1;
								emit_st = ST_NOTQ;
							end
						endcase
					end
				end
			end
			BK_INSERT: begin
				// ties go behind every queued job with the same tick
				if (scan_hit) begin
					pos_inc = 1'b1;
				end else if (out_free) begin
					ins_do  = 1'b1;
					inq_set = 1'b1;
					emit    = 1'b1;
					emit_id = id_q;
					state_d = BK_IDLE;
				end
			end
			BK_DELETE: begin
				if (head_id == id_q) begin
					if (out_free) begin
						rm_do   = 1'b1;
						inq_clr = 1'b1;
						emit    = 1'b1;
						emit_id = id_q;
						state_d = BK_IDLE;
					end
				end else begin
					pos_inc = 1'b1;
				end
			end
			BK_RUN: begin
				// pos stays at the head; one fired id is held back to know last
				inq_clr_idx = head_id[IW-1:0];
				emit_id     = pend_id_q;
				if (scan_hit) begin
					if (!pend_vld_q || out_free) begin
						emit       = pend_vld_q;
						emit_st    = ST_FIRED;
						emit_last  = 1'b0;
						pend_ld    = 1'b1;
						pend_vld_d = 1'b1;
						rm_do      = 1'b1;
						inq_clr    = 1'b1;
					end
				end else if (out_free) begin
					emit       = 1'b1;
					emit_st    = pend_vld_q ? ST_FIRED : ST_NONE;
					emit_id    = pend_vld_q ? pend_id_q : '0;
					pend_vld_d = 1'b0;
					state_d    = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			inq_q      <= '0;
			pos_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (ins_do) begin
				count_q <= count_q + 1'b1;
			end else if (rm_do) begin
				count_q <= count_q - 1'b1;
			end
			if (inq_set) begin
				inq_q[id_q[IW-1:0]] <= 1'b1;
			end else if (inq_clr) begin
				inq_q[inq_clr_idx] <= 1'b0;
			end
			if (pos_clr) begin
				pos_q <= '0;
			end else if (pos_inc) begin
				pos_q <= pos_q + 1'b1;
			end
			pend_vld_q <= pend_vld_d;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// tick and period store, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				due_q[i] <= '0;
				per_q[i] <= '0;
			end
		end else begin
			if (due_we) begin
				due_q[hid] <= due_wd;
			end
			if (per_we) begin
				per_q[hid] <= item.period;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctx_ld) begin
			key_q <= key_d;
			id_q  <= item.job_id;
		end
		if (pend_ld) begin
			pend_id_q <= head_id;
		end
		if (emit) begin
			out_st_q   <= emit_st;
			out_id_q   <= emit_id;
			out_last_q <= emit_last;
		end
	end

	// ordered list: each entry at or behind pos shifts on its own for insert and removal
	for (genvar g = 0; g < SLOTS; g++) begin : g_order
		always_ff @(posedge clk) begin
			if (ins_do) begin
				if (CW'(g) == pos_q) begin
					order_q[g] <= id_q;
				end else if (CW'(g) > pos_q) begin
					if (g > 0) begin
						order_q[g] <= order_q[(g > 0) ? g - 1 : 0];
					end
				end
			end else if (rm_do) begin
				if ((CW'(g) >= pos_q) && (g < SLOTS - 1)) begin
					order_q[g] <= order_q[(g < SLOTS - 1) ? g + 1 : g];
				end
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_id_q);
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/sorted_timer_job_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_job_queue
// timer job slots kept in an ordered list by due tick, with create, run to
// tick, periodic reschedule and delete commands
// ----------------------------------------------------------------------------
//
// channel   dir  signals                      content
// s_axis    in   tvalid tready tdata tuser    one command: cmd in tuser, job_id,
//                                             tick_value, repeat_period in tdata
// m_axis    out  tvalid tready tdata tuser    one result: status in tuser,
//                tlast                        fired_job in tdata, last as tlast
//
// a command is registered in the input stage, then waits in a two-entry
// queue until the back end is free; commands that only answer are answered
// from idle, create and reschedule walk past the queued jobs due no later
// than the new tick, delete walks to its place in the list, and run fires
// the due jobs from the head; the walk over the ordered list goes one entry
// a cycle through a single tick read port unless a stalled result holds it
// reset clears the control state and job store, no clearing pass follows it
// a stalled result stays in the output register; the back end waits for it
// and the front keeps taking commands until the queue fills
// ----------------------------------------------------------------------------
module sorted_timer_job_queue import stq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command transfers
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // job_id[3:0], tick_value[35:4],
	                                               // repeat_period[67:36], zero pad
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // cmd[1:0]
	// result transfers
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // fired_job[3:0], zero pad
	output logic [STATUS_W-1:0]    m_axis_tuser,  // status[2:0]
	output logic                   m_axis_tlast   // last result of a command
);

	// job ids are four bits wide, so no more than sixteen slots are usable
	localparam int SLOTS = (DEPTH < (1 << ID_W)) ? DEPTH : (1 << ID_W);

	logic      front_vld;
	logic      front_rdy;
	cmd_item_t front_item;
	logic      back_vld;
	logic      back_pop;
	cmd_item_t back_item;

	// decode and range check
	stq_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.item_vld      (front_vld),
		.item_rdy      (front_rdy),
		.item          (front_item)
	);

	// decouples command intake from list processing
	stq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (front_vld),
		.push_rdy  (front_rdy),
		.push_item (front_item),
		.pop_vld   (back_vld),
		.pop_rdy   (back_pop),
		.pop_item  (back_item)
	);

	// ordered list, job store and result register
	stq_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_vld      (back_vld),
		.item_pop      (back_pop),
		.item          (back_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ rtl/stq_checker.sv @@
// ----------------------------------------------------------------------------
// stq_checker
// port-level checks on the result stream of the job queue
// ----------------------------------------------------------------------------
`include "sorted_timer_job_queue_defines.svh"

module stq_checker import stq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [STATUS_W-1:0]    m_axis_tuser,
	input logic                   m_axis_tlast
);

	// a stalled result holds
	`STQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

	// only fired results may leave a run open
	`STQ_ASSERT_NOW(a_single_last, m_axis_tvalid && (m_axis_tuser != ST_FIRED), m_axis_tlast, "single result without last")

	// nothing due reports job zero
	`STQ_ASSERT_NOW(a_none_zero, m_axis_tvalid && (m_axis_tuser == ST_NONE), m_axis_tdata == '0, "none due with nonzero job")

	// an open run continues with fired results only
	`STQ_ASSERT_NXT(a_run_cont, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid || (m_axis_tuser == ST_FIRED), "run interrupted by other result")

endmodule

bind sorted_timer_job_queue stq_checker u_stq_checker (.*);
